### rtl/lss_pkg.sv
// ----------------------------------------------------------------------------
// Line scan sensor sequencer package
// Shared item types and operation codes for the readout sequencer.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned IDX_W    = 7;

  typedef enum logic [0:0] {
    OP_TICK         = 1'b0,
    OP_PERIOD_START = 1'b1
  } lss_op_e;

  typedef struct packed {
    lss_op_e               op;
    logic [SAMPLE_W-1:0]   adc_sample;
    logic                  reader_done;
  } lss_in_t;

  typedef struct packed {
    logic                  clk_level;
    logic                  si_level;
    logic                  store_valid;
    logic                  store_buffer;
    logic [IDX_W-1:0]      store_index;
    logic [SAMPLE_W-1:0]   store_value;
    logic                  line_swapped;
    logic                  presented_buffer;
    logic                  waiting_for_reader;
    logic                  capture_enabled;
  } lss_out_t;

endpackage

### rtl/line_scan_sensor_readout_sequencer_top.sv
// ----------------------------------------------------------------------------
// Line scan sensor readout sequencer
// Drives the CLK and SI pins of a linear sensor and steers converter samples
// into two ping-pong line buffers, one result transfer per input transfer.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+---------------------
//   in       | input     | in_valid_i / in_stall_o | in_data_i  (lss_in_t)
//   out      | output    | out_valid_o/out_stall_i | out_data_o (lss_out_t)
//
// One item per cycle while the output is not stalled; each item passes
// through the input register, then the result register. The core updates its
// state in the cycle an item moves into the result register. Reset clears
// the pin levels, buffer select and flags and sets the position counter to
// its start value at once. A stall on the output holds the result register;
// the input register then fills and in_stall_o rises in the same cycle.
module line_scan_sensor_readout_sequencer_top #(
  parameter int unsigned LINE_PIXELS = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lss_pkg::lss_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lss_pkg::lss_out_t out_data_o
);

  logic              in_valid_q;
  lss_pkg::lss_in_t  in_data_q;
  logic              out_valid_q;
  lss_pkg::lss_out_t out_data_q;
  lss_pkg::lss_out_t result;
  logic              out_free;
  logic              advance;
  logic              in_xfer;

  // The result register can take a new result when empty or being drained
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  lss_core #(
    .LINE_PIXELS(LINE_PIXELS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .commit_i(advance),
    .item_i  (in_data_q),
    .result_o(result)
  );

  // Input register: load on every transfer, empty once the item moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_data_q <= in_data_i;
    end
  end

  // Result register: hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // An empty result register never pushes back on the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> !in_stall_o)
    else $error("input stalled with empty result register");

  // A pixel is stored only while capture is running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.store_valid) |-> out_data_o.capture_enabled)
    else $error("pixel stored with capture disabled");

  // A stalled tick neither stores nor swaps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.waiting_for_reader) |->
      (!out_data_o.store_valid && !out_data_o.line_swapped))
    else $error("stalled tick stored or swapped");

  // A held result stays put until it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && out_valid_q && out_stall_i) |=> 0)
    else $error("result register overwritten while stalled");

endmodule

### rtl/lss_core.sv
// ----------------------------------------------------------------------------
// Sequencer core
// Holds the sensor pin and line buffer state and computes one result per item.
// ----------------------------------------------------------------------------
module lss_core #(
  parameter int unsigned LINE_PIXELS = 128
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             commit_i,
  input  lss_pkg::lss_in_t item_i,
  output lss_pkg::lss_out_t result_o
);

  localparam int unsigned POS_W = $clog2(2 * LINE_PIXELS + 1) + 1;
  localparam int unsigned CNT_W = $clog2(LINE_PIXELS + 1);
  localparam logic signed [POS_W-1:0] PosStart = -POS_W'(2);
  localparam logic signed [POS_W-1:0] PosSiRise = -POS_W'(1);
  localparam logic signed [POS_W-1:0] PosSiFall = POS_W'(1);
  localparam logic signed [POS_W-1:0] PosFirst = POS_W'(2);
  localparam logic signed [POS_W-1:0] PosEnd = POS_W'(2 * LINE_PIXELS);
  localparam logic [CNT_W-1:0] LineFull = CNT_W'(LINE_PIXELS);

  logic                    clock_q, clock_d;
  logic                    si_q, si_d;
  logic signed [POS_W-1:0] pos_q, pos_d;
  logic                    en_q, en_d;
  logic [CNT_W-1:0]        stored_q, stored_d;
  logic                    wsel_q, wsel_d;
  logic                    presented_q, presented_d;

  logic full, stall, swap;

  always_comb begin
    clock_d     = clock_q;
    si_d        = si_q;
    pos_d       = pos_q;
    en_d        = en_q;
    stored_d    = stored_q;
    wsel_d      = wsel_q;
    presented_d = presented_q;
    full        = 1'b0;
    stall       = 1'b0;
    swap        = 1'b0;
    result_o    = '0;

    if (item_i.op == lss_pkg::OP_PERIOD_START) begin
      en_d = 1'b1;
    end else if (en_q) begin
      clock_d = ~clock_q;
      full    = (stored_q >= LineFull);
      stall   = full && !(item_i.reader_done || !presented_q);
      swap    = full && !stall;
      if (swap) begin
        wsel_d      = ~wsel_q;
        presented_d = 1'b1;
        stored_d    = '0;
      end
      if (!stall) begin
        if (pos_q >= PosFirst && pos_q < PosEnd) begin
          // Store on the falling clock edge only
          if (!clock_d) begin
            result_o.store_valid  = 1'b1;
            result_o.store_buffer = wsel_d;
            result_o.store_index  = lss_pkg::IDX_W'(pos_q >> 1);
            result_o.store_value  = item_i.adc_sample;
            stored_d              = stored_d + CNT_W'(1);
          end
          pos_d = pos_q + POS_W'(1);
        end else if (pos_q < PosFirst) begin
          if (pos_q == PosSiRise) begin
            si_d = 1'b1;
          end else if (pos_q == PosSiFall) begin
            si_d                  = 1'b0;
            result_o.store_valid  = 1'b1;
            result_o.store_buffer = wsel_d;
            result_o.store_value  = item_i.adc_sample;
            stored_d              = stored_d + CNT_W'(1);
          end
          pos_d = pos_q + POS_W'(1);
        end else begin
          // End of line: park the clock low and wait for the next period
          clock_d = 1'b0;
          pos_d   = PosStart;
          en_d    = 1'b0;
        end
      end
    end

    result_o.clk_level          = clock_d;
    result_o.si_level           = si_d;
    result_o.line_swapped       = swap;
    result_o.presented_buffer   = presented_d & ~wsel_d;
    result_o.waiting_for_reader = stall;
    result_o.capture_enabled    = en_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q     <= 1'b0;
      si_q        <= 1'b0;
      pos_q       <= PosStart;
      en_q        <= 1'b0;
      stored_q    <= '0;
      wsel_q      <= 1'b0;
      presented_q <= 1'b0;
    end else if (commit_i) begin
      clock_q     <= clock_d;
      si_q        <= si_d;
      pos_q       <= pos_d;
      en_q        <= en_d;
      stored_q    <= stored_d;
      wsel_q      <= wsel_d;
      presented_q <= presented_d;
    end
  end

endmodule
